// ===== rtl/lst_pkg.sv =====
`default_nettype none

package lst_pkg;

   // Number of sensors on the bar; only the low bits of the 16-bit bar exist.
   localparam int SENSOR_COUNT = 16;
   localparam int BAR_BITS     = (SENSOR_COUNT >= 16) ? 16 : SENSOR_COUNT;

   // The bar is scanned two bits per cycle.
   localparam int SCAN_STEPS = (BAR_BITS + 1) / 2;
   localparam int SCAN_BITS  = 2 * SCAN_STEPS;
   localparam int STEP_W     = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

   // Weighted sum and population count of the tracked bar.
   localparam int NOM_W = $clog2(SCAN_BITS * (SCAN_BITS + 1) / 2 + 1);
   localparam int DEN_W = $clog2(BAR_BITS + 1);

   // Half-range divisor, taken as one when the bar has two sensors or fewer.
   localparam int HALF   = (SENSOR_COUNT > 2) ? SENSOR_COUNT - 2 : 1;
   localparam int DIV_W  = $clog2(HALF * BAR_BITS + 1);
   localparam int REM_W  = DIV_W + 1;
   localparam int DIFF_W = $clog2((SENSOR_COUNT + 1) * BAR_BITS + 1) + 1;

   // Quotient: one integer bit and the Q1.14 fraction.
   localparam int FRAC_BITS = 14;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int QCNT_W    = $clog2(QUO_W);

   // Tracking status codes.
   localparam logic [1:0] STATUS_LOST   = 2'd0;
   localparam logic [1:0] STATUS_NORMAL = 2'd1;
   localparam logic [1:0] STATUS_LEFT   = 2'd2;
   localparam logic [1:0] STATUS_RIGHT  = 2'd3;

   // Marker byte value.
   localparam logic [7:0] MARKER_BYTE = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } lst_state_type;

endpackage

`default_nettype wire

// ===== rtl/line_sensor_tracker_unit.sv =====
// Channel   Ports                        Direction  Moves
// req       req_valid / req_ready        in         one status packet and drive command
// rsp       rsp_valid / rsp_ready        out        one reply and tracking result
//
// Each packet runs through these steps after its transfer: the scan reads the bar
// two bits at a time, the prep step forms the centroid terms, the restoring divider
// makes one quotient bit each step, and the finish step loads the output register once it is free.
// The next packet is taken only once the block is back in idle.
// Reset clears the tracked bar, the lost flag and the handshake state. A stalled
// result waits in the output register while the next packet is worked on.
`default_nettype none

module line_sensor_tracker_unit import lst_pkg::*; (
   input  wire                clock,
   input  wire                reset,

   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_rx_sync,
   input  wire  [7:0]         req_error_code,
   input  wire  signed [15:0] req_measured_left,
   input  wire  signed [15:0] req_measured_right,
   input  wire  [7:0]         req_sensor_high,
   input  wire  [7:0]         req_sensor_low,
   input  wire  signed [15:0] req_command_left,
   input  wire  signed [15:0] req_command_right,
   input  wire  [7:0]         req_command_accel,

   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [7:0]         rsp_reply_sync,
   output logic signed [15:0] rsp_reply_left,
   output logic signed [15:0] rsp_reply_right,
   output logic [7:0]         rsp_reply_accel,
   output logic [7:0]         rsp_error_out,
   output logic signed [15:0] rsp_speed_left,
   output logic signed [15:0] rsp_speed_right,
   output logic [15:0]        rsp_tracked_bar,
   output logic signed [15:0] rsp_direction,
   output logic [1:0]         rsp_track_status,
   output logic               rsp_line_lost
);

   // Control state.
   lst_state_type             state_ff, state_in;
   logic [BAR_BITS-1:0]       prev_bar_ff, prev_bar_in;
   logic                      lost_ff, lost_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [QCNT_W-1:0]         qcnt_ff, qcnt_in;

   // Working registers.
   logic [SCAN_BITS-1:0]      bar_sh_ff, bar_sh_in;
   logic [NOM_W-1:0]          weight_ff, weight_in;
   logic [NOM_W-1:0]          nom_ff, nom_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]          div_ff, div_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   logic [1:0]                status_ff, status_in;

   // Packet fields held from the input transfer.
   logic [7:0]                sync_ff;
   logic [7:0]                err_ff;
   logic signed [15:0]        meas_l_ff, meas_r_ff;
   logic signed [15:0]        cmd_l_ff, cmd_r_ff;
   logic [7:0]                accel_ff;
   logic                      mark_l_ff, mark_r_ff;
   logic [BAR_BITS-1:0]       bar_ff;

   // Output register.
   logic [7:0]                out_sync_ff;
   logic signed [15:0]        out_cmd_l_ff, out_cmd_r_ff;
   logic [7:0]                out_accel_ff;
   logic [7:0]                out_err_ff;
   logic signed [15:0]        out_meas_l_ff, out_meas_r_ff;
   logic [15:0]               out_bar_ff;
   logic signed [15:0]        out_dir_ff;
   logic [1:0]                out_status_ff;
   logic                      out_lost_ff;

   // Combinational helpers.
   logic                      req_xfer;
   logic                      out_load;
   logic [15:0]               raw_word;
   logic [BAR_BITS-1:0]       raw_bar;
   logic [BAR_BITS-1:0]       dilated;
   logic [BAR_BITS-1:0]       new_bar;
   logic [DIFF_W-1:0]         two_nom;
   logic [DIFF_W-1:0]         scaled_den;
   logic                      rem_ge;
   logic [REM_W-1:0]          rem_sub;
   logic [15:0]               dir_mag;
   logic signed [15:0]        dir_value;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Mask the raw bar by the dilated previous bar, unless that bar was empty.
   always_comb begin
      raw_word = {req_sensor_high, req_sensor_low};
      raw_bar  = raw_word[BAR_BITS-1:0];
      dilated  = (prev_bar_ff << 1) | prev_bar_ff | (prev_bar_ff >> 1);
      new_bar  = (prev_bar_ff == '0) ? raw_bar : (raw_bar & dilated);
   end

   // Centroid numerator terms and one restoring divide step.
   always_comb begin
      two_nom    = DIFF_W'({nom_ff, 1'b0});
      scaled_den = DIFF_W'(den_ff) * DIFF_W'(SENSOR_COUNT + 1);
      rem_ge     = (rem_ff >= {1'b0, div_ff});
      rem_sub    = rem_ge ? (rem_ff - {1'b0, div_ff}) : rem_ff;
   end

   // Signed direction; an empty bar gives zero.
   always_comb begin
      dir_mag = 16'(quo_ff);
      if (den_ff == '0) begin
         dir_value = '0;
      end else if (neg_ff) begin
         dir_value = signed'(16'(-dir_mag));
      end else begin
         dir_value = signed'(dir_mag);
      end
   end

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_bar_ff  <= '0;
         lost_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         qcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         prev_bar_ff  <= prev_bar_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         qcnt_ff      <= qcnt_in;
      end
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      prev_bar_in  = prev_bar_ff;
      lost_in      = lost_ff;
      step_in      = step_ff;
      qcnt_in      = qcnt_ff;
      bar_sh_in    = bar_sh_ff;
      weight_in    = weight_ff;
      nom_in       = nom_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      status_in    = status_ff;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               prev_bar_in = new_bar;
               bar_sh_in   = SCAN_BITS'(new_bar);
               weight_in   = NOM_W'(1);
               nom_in      = '0;
               den_in      = '0;
               step_in     = '0;
               state_in    = ST_SCAN;
            end
         end

         // Two bar bits per cycle into the weighted sum and the count.
         ST_SCAN: begin
            nom_in    = nom_ff
                      + (bar_sh_ff[0] ? weight_ff : '0)
                      + (bar_sh_ff[1] ? NOM_W'(weight_ff + NOM_W'(1)) : '0);
            den_in    = den_ff + DEN_W'(bar_sh_ff[0]) + DEN_W'(bar_sh_ff[1]);
            bar_sh_in = bar_sh_ff >> 2;
            weight_in = NOM_W'(weight_ff + NOM_W'(2));
            step_in   = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff == STEP_W'(SCAN_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end

         // Numerator magnitude, sign, divisor and status.
         ST_PREP: begin
            neg_in  = (scaled_den > two_nom);
            rem_in  = neg_in ? REM_W'(scaled_den - two_nom) : REM_W'(two_nom - scaled_den);
            div_in  = DIV_W'(den_ff) * DIV_W'(HALF);
            quo_in  = '0;
            qcnt_in = '0;
            status_in = STATUS_NORMAL;
            if (mark_l_ff) begin
               status_in = STATUS_LEFT;
            end
            if (mark_r_ff) begin
               status_in = STATUS_RIGHT;
            end
            if (den_ff < DEN_W'(2)) begin
               status_in = STATUS_LOST;
               lost_in   = 1'b1;
            end
            state_in = ST_DIVIDE;
         end

         // One quotient bit per cycle, integer bit first.
         ST_DIVIDE: begin
            quo_in  = {quo_ff[QUO_W-2:0], rem_ge};
            rem_in  = {rem_sub[REM_W-2:0], 1'b0};
            qcnt_in = QCNT_W'(qcnt_ff + QCNT_W'(1));
            if (qcnt_ff == QCNT_W'(QUO_W - 1)) begin
               state_in = ST_FINISH;
            end
         end

         // Load the output register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Working and held packet registers.
   always_ff @(posedge clock) begin
      bar_sh_ff <= bar_sh_in;
      weight_ff <= weight_in;
      nom_ff    <= nom_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      status_ff <= status_in;
      if (req_xfer) begin
         sync_ff   <= req_rx_sync;
         err_ff    <= req_error_code;
         meas_l_ff <= req_measured_left;
         meas_r_ff <= req_measured_right;
         cmd_l_ff  <= req_command_left;
         cmd_r_ff  <= req_command_right;
         accel_ff  <= req_command_accel;
         mark_l_ff <= (req_sensor_high == MARKER_BYTE);
         mark_r_ff <= (req_sensor_low == MARKER_BYTE);
         bar_ff    <= new_bar;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sync_ff   <= 8'(sync_ff + 8'd1);
         out_cmd_l_ff  <= cmd_l_ff;
         out_cmd_r_ff  <= cmd_r_ff;
         out_accel_ff  <= accel_ff;
         out_err_ff    <= err_ff;
         out_meas_l_ff <= meas_l_ff;
         out_meas_r_ff <= meas_r_ff;
         out_bar_ff    <= 16'(bar_ff);
         out_dir_ff    <= dir_value;
         out_status_ff <= status_ff;
         out_lost_ff   <= lost_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_sync   = out_sync_ff;
   assign rsp_reply_left   = out_cmd_l_ff;
   assign rsp_reply_right  = out_cmd_r_ff;
   assign rsp_reply_accel  = out_accel_ff;
   assign rsp_error_out    = out_err_ff;
   assign rsp_speed_left   = out_meas_l_ff;
   assign rsp_speed_right  = out_meas_r_ff;
   assign rsp_tracked_bar  = out_bar_ff;
   assign rsp_direction    = out_dir_ff;
   assign rsp_track_status = out_status_ff;
   assign rsp_line_lost    = out_lost_ff;

endmodule

`default_nettype wire

// ===== rtl/lst_checker.sv =====
`default_nettype none

module lst_checker import lst_pkg::*; (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire [15:0]        rsp_tracked_bar,
   input wire signed [15:0] rsp_direction,
   input wire [1:0]         rsp_track_status,
   input wire               rsp_line_lost
);

   // A stalled result holds its tracking fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tracked_bar)
                                 && $stable(rsp_direction))
      else $error("stalled result changed");

   // A lost status always comes with the sticky lost flag.
   a_lost_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_track_status == STATUS_LOST |-> rsp_line_lost)
      else $error("lost status without lost flag");

   // An empty tracked bar gives zero direction and lost status.
   a_empty_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tracked_bar == 16'd0 |->
         rsp_direction == 16'sd0 && rsp_track_status == STATUS_LOST)
      else $error("empty bar gave a direction or status");

   // The block works on one packet at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second packet taken while busy");

   // After reset no result is shown and a packet can be taken.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind line_sensor_tracker_unit lst_checker u_lst_checker (.*);

`default_nettype wire
